// ===== src/tbpm_pkg.sv =====
// tbpm_pkg: shared constants, status codes and types of the tiered buffer pool manager
// no dependencies
`default_nettype none

package tbpm_pkg;

    localparam int TIER_COUNT_DEF  = 4;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int HANDLE_BITS_DEF = 32;

    // programmable tier size registers and the apb address width that covers them
    localparam int CFG_REGS  = 4;
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [2:0] ST_HIT         = 3'd0;
    localparam logic [2:0] ST_ALLOC_TIER  = 3'd1;
    localparam logic [2:0] ST_ALLOC_EXACT = 3'd2;
    localparam logic [2:0] ST_RECYCLED    = 3'd3;
    localparam logic [2:0] ST_CALLER_FREE = 3'd4;
    localparam logic [2:0] ST_IGNORED     = 3'd5;

    typedef struct packed {
        logic                 found;
        logic [DATA_BITS-1:0] size;
    } tier_sel_t;

    // reset size of tier i: 4 KiB growing by 4x per tier
    function automatic logic [DATA_BITS-1:0] tier_reset(input int i);
        logic [63:0] v;
        v = 64'd4096 << (2 * i);
        return v[DATA_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/tiered_buffer_pool_manager.sv =====
// tiered_buffer_pool_manager: free-list buffer pool with size tiers
// depends on tbpm_pkg, tbpm_regs, tbpm_tier_sel, tbpm_stack_mem
//
// Usage:
//   s_ channel takes one request item: s_op (0 get, 1 put), s_byte_size, s_handle.
//   m_ channel returns one result item per request: m_status, m_out_handle,
//   m_granted_bytes and the running hit and alloc counts after that request.
//   The tier sizes sit in four 32-bit apb registers at byte addresses 0, 4, 8, 12;
//   write them only while no request is in flight.
// Timing:
//   a request is accepted in the idle state; in that cycle the tier is chosen,
//   the fill count is moved and the stack memory is read or written. In the
//   response state that follows, the registered memory read data and the status
//   are loaded into the output register once it is free, which raises m_valid.
//   No new request is taken until the last one leaves the response state.
//   If the receiver stalls, the result holds in the output register; one more
//   request is still taken and waits for the output register to free up.
// Reset:
//   all stacks empty, both counters zero, tier sizes 4K, 16K, 64K, 256K bytes.
//   Stack memory contents are not cleared; only entries below a fill count are read.
`default_nettype none

module tiered_buffer_pool_manager
    import tbpm_pkg::*;
#(
    parameter int TIER_COUNT  = TIER_COUNT_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_op,
    input  wire logic [31:0]          s_byte_size,
    input  wire logic [31:0]          s_handle,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [2:0]           m_status,
    output logic      [31:0]          m_out_handle,
    output logic      [31:0]          m_granted_bytes,
    output logic      [31:0]          m_hit_total,
    output logic      [31:0]          m_alloc_total,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready
);

    localparam int TW = $clog2(TIER_COUNT);
    localparam int PW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int HW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
    localparam int AW = TW + PW;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic [TIER_COUNT-1:0][DATA_BITS-1:0] tier_bytes;
    tier_sel_t                            sel;
    logic [TW-1:0]                        sel_idx;

    logic                 state_reg, state_next;
    logic [FW-1:0]        fill_reg [TIER_COUNT];
    logic [31:0]          hit_cnt_reg, alloc_cnt_reg;
    logic [2:0]           status_reg;
    logic [31:0]          granted_reg;
    logic                 hit_reg;

    logic                 m_valid_reg;
    logic [2:0]           m_status_reg;
    logic [31:0]          m_out_handle_reg;
    logic [31:0]          m_granted_reg;
    logic [31:0]          m_hit_total_reg;
    logic [31:0]          m_alloc_total_reg;

    logic                 accept;
    logic [FW-1:0]        cur_fill, fill_m1;
    logic [HW-1:0]        handle_in;
    logic                 do_pop, do_push;
    logic [2:0]           status_next;
    logic [31:0]          granted_next;
    logic [HW-1:0]        rd_data;

    tbpm_regs #(
        .TIER_COUNT (TIER_COUNT)
    ) u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .tier_bytes (tier_bytes)
    );

    tbpm_tier_sel #(
        .TIER_COUNT (TIER_COUNT),
        .TW         (TW)
    ) u_tier_sel (
        .tier_bytes (tier_bytes),
        .byte_size  (s_byte_size),
        .sel        (sel),
        .sel_idx    (sel_idx)
    );

    assign pready  = 1'b1;
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    assign cur_fill  = fill_reg[sel_idx];
    assign fill_m1   = cur_fill - 1'b1;
    assign handle_in = s_handle[HW-1:0];

    always_comb begin
        do_pop       = 1'b0;
        do_push      = 1'b0;
        granted_next = '0;
        status_next  = ST_IGNORED;
        case (s_op)
            OP_GET: begin
                if (sel.found) begin
                    granted_next = sel.size;
                    if (cur_fill != '0) begin
                        do_pop      = 1'b1;
                        status_next = ST_HIT;
                    end else begin
                        status_next = ST_ALLOC_TIER;
                    end
                end else begin
                    granted_next = s_byte_size;
                    status_next  = ST_ALLOC_EXACT;
                end
            end
            OP_PUT: begin
                if (handle_in == '0) begin
                    status_next = ST_IGNORED;
                end else if (sel.found && s_byte_size == sel.size
                             && cur_fill < FW'(STACK_DEPTH)) begin
                    do_push     = 1'b1;
                    status_next = ST_RECYCLED;
                end else begin
                    status_next = ST_CALLER_FREE;
                end
            end
            default: begin
                status_next = ST_IGNORED;
            end
        endcase
    end

    tbpm_stack_mem #(
        .AW (AW),
        .DW (HW)
    ) u_stack_mem (
        .aclk    (aclk),
        .wr_en   (accept && do_push),
        .wr_addr ({sel_idx, cur_fill[PW-1:0]}),
        .wr_data (handle_in),
        .rd_en   (accept && do_pop),
        .rd_addr ({sel_idx, fill_m1[PW-1:0]}),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            hit_cnt_reg   <= '0;
            alloc_cnt_reg <= '0;
            for (int i = 0; i < TIER_COUNT; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (accept) begin
                if (do_pop) begin
                    fill_reg[sel_idx] <= fill_m1;
                    hit_cnt_reg       <= hit_cnt_reg + 32'd1;
                end else if (do_push) begin
                    fill_reg[sel_idx] <= cur_fill + 1'b1;
                end
                if (status_next == ST_ALLOC_TIER || status_next == ST_ALLOC_EXACT) begin
                    alloc_cnt_reg <= alloc_cnt_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            hit_reg     <= do_pop;
        end
    end

    // output register, loaded once the pending item leaves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_RESP && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_RESP && (!m_valid_reg || m_ready)) begin
            m_status_reg      <= status_reg;
            m_out_handle_reg  <= hit_reg ? 32'(rd_data) : 32'd0;
            m_granted_reg     <= granted_reg;
            m_hit_total_reg   <= hit_cnt_reg;
            m_alloc_total_reg <= alloc_cnt_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_out_handle    = m_out_handle_reg;
    assign m_granted_bytes = m_granted_reg;
    assign m_hit_total     = m_hit_total_reg;
    assign m_alloc_total   = m_alloc_total_reg;

endmodule

`default_nettype wire

// ===== src/tbpm_regs.sv =====
// tbpm_regs: apb register file holding the tier sizes
// depends on tbpm_pkg
`default_nettype none

module tbpm_regs
    import tbpm_pkg::*;
#(
    parameter int TIER_COUNT = TIER_COUNT_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [ADDR_BITS-1:0]                 paddr,
    input  wire logic [DATA_BITS-1:0]                 pwdata,
    output logic      [DATA_BITS-1:0]                 prdata,
    output logic      [TIER_COUNT-1:0][DATA_BITS-1:0] tier_bytes
);

    localparam int NCFG = (TIER_COUNT < CFG_REGS) ? TIER_COUNT : CFG_REGS;

    logic [ADDR_BITS-3:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;

    for (genvar i = 0; i < TIER_COUNT; i++) begin : g_tier
        if (i < NCFG) begin : g_prog
            logic [DATA_BITS-1:0] size_reg;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    size_reg <= tier_reset(i);
                end else if (wr_en && reg_idx == (ADDR_BITS-2)'(i)) begin
                    size_reg <= pwdata;
                end
            end
            assign tier_bytes[i] = size_reg;
        end else begin : g_fixed
            assign tier_bytes[i] = tier_reset(i);
        end
    end

    always_comb begin
        prdata = '0;
        for (int i = 0; i < NCFG; i++) begin
            if (reg_idx == (ADDR_BITS-2)'(i)) begin
                prdata = tier_bytes[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/tbpm_tier_sel.sv =====
// tbpm_tier_sel: picks the first tier whose size covers a byte count
// depends on tbpm_pkg
`default_nettype none

module tbpm_tier_sel
    import tbpm_pkg::*;
#(
    parameter int TIER_COUNT = TIER_COUNT_DEF,
    parameter int TW         = $clog2(TIER_COUNT)
) (
    input  wire logic [TIER_COUNT-1:0][DATA_BITS-1:0] tier_bytes,
    input  wire logic [DATA_BITS-1:0]                 byte_size,
    output tier_sel_t                                 sel,
    output logic      [TW-1:0]                        sel_idx
);

    // scan from the top so the lowest covering tier wins
    always_comb begin
        sel.found = 1'b0;
        sel.size  = '0;
        sel_idx   = '0;
        for (int i = TIER_COUNT - 1; i >= 0; i--) begin
            if (byte_size <= tier_bytes[i]) begin
                sel.found = 1'b1;
                sel.size  = tier_bytes[i];
                sel_idx   = TW'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/tbpm_stack_mem.sv =====
// tbpm_stack_mem: single-port-write, registered-read memory holding all free stacks
// depends on nothing but its parameters
`default_nettype none

module tbpm_stack_mem #(
    parameter int AW = 8,
    parameter int DW = 32
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [1 << AW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/tbpm_checker.sv =====
// tbpm_checker: port-level assertions for the tiered buffer pool manager, bound to the top
// depends on tbpm_pkg and tiered_buffer_pool_manager
`default_nettype none

module tbpm_checker
    import tbpm_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [31:0] m_out_handle,
    input wire logic [31:0] m_granted_bytes,
    input wire logic [31:0] m_hit_total
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_hit_total))
        else $error("result changed while stalled");

    // one item in the response state at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while previous one in flight");

    a_handle_only_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_HIT |-> m_out_handle == 32'd0)
        else $error("handle returned without a pool hit");

    a_put_grants_nothing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_RECYCLED || m_status == ST_CALLER_FREE
                    || m_status == ST_IGNORED) |-> m_granted_bytes == 32'd0)
        else $error("put reported granted bytes");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_IGNORED)
        else $error("status code out of range");

endmodule

bind tiered_buffer_pool_manager tbpm_checker u_tbpm_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_out_handle    (m_out_handle),
    .m_granted_bytes (m_granted_bytes),
    .m_hit_total     (m_hit_total)
);

`default_nettype wire
